[hw/rtl/sle_pkg.sv]
`timescale 1ns / 1ps

package sle_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SHOW_ASC  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SHOW_DESC = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DEL_MIN   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DEL_MAX   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_DEL_VAL   = 3'd7;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

[hw/rtl/sorted_list_engine.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake               Payload
// command   in         start, busy             in_mode, in_operand_value
// result    out        out_valid (one cycle)   out_item_value, out_element_count,
//                                              out_status, out_is_last
//
// Clear, count, an insert into a full list and any show or delete on an empty list answer
// straight from idle. Insert scans entries, moves entries up one place and then writes;
// delete value scans entries, delete min and max fetch the end entry, and every delete
// then moves entries down one place and finishes. Show reads and then outputs each word.
// Each read goes through the single registered read port of the value store. Reset
// empties the list without clearing the store; receiver no stall.

module sorted_list_engine #(
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [sle_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [sle_pkg::VALUE_W-1:0]  in_operand_value,
  output logic                                out_valid,
  output logic signed [sle_pkg::VALUE_W-1:0]  out_item_value,
  output logic [sle_pkg::COUNT_W-1:0]         out_element_count,
  output logic [sle_pkg::STAT_W-1:0]          out_status,
  output logic                                out_is_last
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW      = $clog2(DEPTH + 1);
  localparam int CntOutW = sle_pkg::COUNT_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SHF_RD,
    S_SHF_WR,
    S_PUT,
    S_SHOW_RD,
    S_SHOW_OUT,
    S_VAL_RD,
    S_VAL_CAP,
    S_RM_RD,
    S_RM_WR
  } state_t;

  state_t                             state_r, state_nxt;
  logic [sle_pkg::MODE_W-1:0]         mode_r, mode_nxt;
  logic signed [sle_pkg::VALUE_W-1:0] opv_r, opv_nxt;
  logic signed [sle_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [IW-1:0]                      count_r, count_nxt;
  logic [IW-1:0]                      idx_r, idx_nxt;
  logic [IW-1:0]                      pos_r, pos_nxt;

  logic                               out_valid_r, out_valid_nxt;
  logic signed [sle_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [sle_pkg::COUNT_W-1:0]        out_count_r, out_count_nxt;
  logic [sle_pkg::STAT_W-1:0]         out_status_r, out_status_nxt;
  logic                               out_last_r, out_last_nxt;

  logic                               ram_we;
  logic [IW-1:0]                      ram_waddr_full;
  logic signed [sle_pkg::VALUE_W-1:0] ram_wdata;
  logic [IW-1:0]                      ram_raddr_full;
  logic signed [sle_pkg::VALUE_W-1:0] ram_rdata;
  sle_pkg::cmp_res_t                  cmp;

  logic [IW-1:0]                      idx_inc;
  logic [IW-1:0]                      idx_dec;
  logic [IW-1:0]                      rev_idx;

  sle_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr_full[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr_full[AW-1:0]),
    .rdata (ram_rdata)
  );

  sle_cmp u_cmp (
    .a   (ram_rdata),
    .b   (opv_r),
    .res (cmp)
  );

  assign idx_inc = idx_r + IW'(1);
  assign idx_dec = idx_r - IW'(1);
  assign rev_idx = count_r - IW'(1) - idx_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    opv_nxt        = opv_r;
    val_nxt        = val_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr_full = idx_r;
    ram_wdata      = ram_rdata;
    ram_raddr_full = idx_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt       = in_mode;
          opv_nxt        = in_operand_value;
          idx_nxt        = '0;
          out_value_nxt  = '0;
          out_count_nxt  = CntOutW'(count_r);
          out_status_nxt = sle_pkg::ST_OK;
          out_last_nxt   = 1'b1;
          case (in_mode)
            sle_pkg::MODE_CLEAR: begin
              count_nxt     = '0;
              out_count_nxt = '0;
              out_valid_nxt = 1'b1;
            end
            sle_pkg::MODE_INSERT: begin
              if (count_r == IW'(DEPTH)) begin
                out_status_nxt = sle_pkg::ST_FULL;
                out_valid_nxt  = 1'b1;
              end else if (count_r == '0) begin
                pos_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                state_nxt = S_SRCH_RD;
              end
            end
            sle_pkg::MODE_COUNT: begin
              out_valid_nxt = 1'b1;
            end
            sle_pkg::MODE_SHOW_ASC, sle_pkg::MODE_SHOW_DESC: begin
              if (count_r == '0) begin
                out_status_nxt = sle_pkg::ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = S_SHOW_RD;
              end
            end
            sle_pkg::MODE_DEL_MIN, sle_pkg::MODE_DEL_MAX: begin
              if (count_r == '0) begin
                out_status_nxt = sle_pkg::ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                pos_nxt   = (in_mode == sle_pkg::MODE_DEL_MIN) ? '0 : count_r - IW'(1);
                state_nxt = S_VAL_RD;
              end
            end
            default: begin
              if (count_r == '0) begin
                out_status_nxt = sle_pkg::ST_EMPTY;
                out_valid_nxt  = 1'b1;
              end else begin
                state_nxt = S_SRCH_RD;
              end
            end
          endcase
        end
      end

      S_SRCH_RD: begin
        ram_raddr_full = idx_r;
        state_nxt      = S_SRCH_CHK;
      end

      S_SRCH_CHK: begin
        if (mode_r == sle_pkg::MODE_INSERT) begin
          if (cmp.lt) begin
            if (idx_inc == count_r) begin
              pos_nxt   = count_r;
              state_nxt = S_PUT;
            end else begin
              idx_nxt   = idx_inc;
              state_nxt = S_SRCH_RD;
            end
          end else begin
            // Open a hole at the found position by moving the tail up one entry.
            pos_nxt   = idx_r;
            idx_nxt   = count_r;
            state_nxt = S_SHF_RD;
          end
        end else begin
          if (cmp.eq) begin
            val_nxt   = opv_r;
            state_nxt = S_RM_RD;
          end else if (idx_inc == count_r) begin
            out_value_nxt  = '0;
            out_count_nxt  = CntOutW'(count_r);
            out_status_nxt = sle_pkg::ST_NOTFOUND;
            out_last_nxt   = 1'b1;
            out_valid_nxt  = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = S_SRCH_RD;
          end
        end
      end

      S_SHF_RD: begin
        ram_raddr_full = idx_dec;
        state_nxt      = S_SHF_WR;
      end

      S_SHF_WR: begin
        ram_we         = 1'b1;
        ram_waddr_full = idx_r;
        ram_wdata      = ram_rdata;
        idx_nxt        = idx_dec;
        state_nxt      = (idx_dec == pos_r) ? S_PUT : S_SHF_RD;
      end

      S_PUT: begin
        ram_we         = 1'b1;
        ram_waddr_full = pos_r;
        ram_wdata      = opv_r;
        count_nxt      = count_r + IW'(1);
        out_value_nxt  = opv_r;
        out_count_nxt  = CntOutW'(count_r + IW'(1));
        out_status_nxt = sle_pkg::ST_OK;
        out_last_nxt   = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_SHOW_RD: begin
        ram_raddr_full = (mode_r == sle_pkg::MODE_SHOW_ASC) ? idx_r : rev_idx;
        state_nxt      = S_SHOW_OUT;
      end

      S_SHOW_OUT: begin
        out_value_nxt  = ram_rdata;
        out_count_nxt  = CntOutW'(count_r);
        out_status_nxt = sle_pkg::ST_OK;
        out_last_nxt   = (idx_inc == count_r);
        out_valid_nxt  = 1'b1;
        idx_nxt        = idx_inc;
        state_nxt      = (idx_inc == count_r) ? S_IDLE : S_SHOW_RD;
      end

      S_VAL_RD: begin
        ram_raddr_full = pos_r;
        state_nxt      = S_VAL_CAP;
      end

      S_VAL_CAP: begin
        val_nxt   = ram_rdata;
        idx_nxt   = pos_r;
        state_nxt = S_RM_RD;
      end

      S_RM_RD: begin
        // Close the gap at idx by pulling each following entry down one place.
        if (idx_inc < count_r) begin
          ram_raddr_full = idx_inc;
          state_nxt      = S_RM_WR;
        end else begin
          count_nxt      = count_r - IW'(1);
          out_value_nxt  = val_r;
          out_count_nxt  = CntOutW'(count_r - IW'(1));
          out_status_nxt = sle_pkg::ST_OK;
          out_last_nxt   = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      S_RM_WR: begin
        ram_we         = 1'b1;
        ram_waddr_full = idx_r;
        ram_wdata      = ram_rdata;
        idx_nxt        = idx_inc;
        state_nxt      = S_RM_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r       <= mode_nxt;
    opv_r        <= opv_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_item_value    = out_value_r;
  assign out_element_count = out_count_r;
  assign out_status        = out_status_r;
  assign out_is_last       = out_last_r;

endmodule

[hw/rtl/sle_ram.sv]
`timescale 1ns / 1ps

module sle_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [AW-1:0]                         waddr,
  input  logic signed [sle_pkg::VALUE_W-1:0]    wdata,
  input  logic [AW-1:0]                         raddr,
  output logic signed [sle_pkg::VALUE_W-1:0]    rdata
);

  logic signed [sle_pkg::VALUE_W-1:0] mem [DEPTH];
  logic signed [sle_pkg::VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/sle_cmp.sv]
`timescale 1ns / 1ps

module sle_cmp (
  input  logic signed [sle_pkg::VALUE_W-1:0] a,
  input  logic signed [sle_pkg::VALUE_W-1:0] b,
  output sle_pkg::cmp_res_t                  res
);

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule
